// File: src/bms_pkg.sv
// shared constants, step codes, command type and trig tables for the bicycle model step
`default_nettype none
package bms_pkg;

  localparam int TRIG_TABLE_BITS = 10;
  localparam int POSITION_FRAC_BITS = 16;
  localparam int TRIG_N = 1 << TRIG_TABLE_BITS;

  localparam int STEER_LIMIT = 12868;
  localparam logic [15:0] TIME_STEP_RESET = 16'd3277;
  localparam logic [15:0] INV_WHEELBASE_RESET = 16'd2048;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  // radians to binary angle, Q16, split into two 15 bit halves
  localparam logic [14:0] UNITS_LO = 15'(683565276 & 32'h7fff);
  localparam logic [14:0] UNITS_HI = 15'(683565276 >> 15);

  // configuration register indexes
  localparam logic [7:0] REG_TIME_STEP = 8'd0;
  localparam logic [7:0] REG_INV_WHEELBASE = 8'd1;

  // controller states, also the datapath step codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL_RATE = 4'd1;
  localparam logic [3:0] ST_CLAMP = 4'd2;
  localparam logic [3:0] ST_INNER = 4'd3;
  localparam logic [3:0] ST_MUL_V = 4'd4;
  localparam logic [3:0] ST_MUL_L = 4'd5;
  localparam logic [3:0] ST_MUL_DT = 4'd6;
  localparam logic [3:0] ST_MUL_ULO = 4'd7;
  localparam logic [3:0] ST_MUL_UHI = 4'd8;
  localparam logic [3:0] ST_YAW = 4'd9;
  localparam logic [3:0] ST_RAD = 4'd10;
  localparam logic [3:0] ST_IXY = 4'd11;
  localparam logic [3:0] ST_XV = 4'd12;
  localparam logic [3:0] ST_XDT = 4'd13;
  localparam logic [3:0] ST_COMMIT = 4'd14;
  localparam logic [3:0] ST_OUT = 4'd15;

  typedef struct packed {
    logic [3:0] step;
    logic       load;
  } dp_cmd_t;

  typedef logic [15:0] trig_tab_t [TRIG_N];

  // shift and subtract quotient, used only while the tables are built
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin (odd) or cos (even) series in Q30, argument within [0, pi/2]
  function automatic longint unsigned trig_series(longint unsigned x, bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned n;
    longint sum;
    x2 = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    n = odd ? 64'd1 : 64'd0;
    sum = longint'(term);
    for (int i = 0; i < 12; i++) begin
      term = udiv64((term * x2) >> 30, (n + 64'd1) * (n + 64'd2));
      n = n + 64'd2;
      if (i[0]) sum = sum + longint'(term);
      else sum = sum - longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // full turn sine, Q1.15
  function automatic trig_tab_t build_sin_tab();
    trig_tab_t tab;
    longint unsigned quarter [TRIG_N/4+1];
    longint unsigned v;
    int j;
    int m;
    for (int k = 0; k <= TRIG_N / 4; k++) begin
      v = (trig_series(64'(k) * HALF_PI_Q30 / (TRIG_N / 4), 1'b1) + 64'd16384) >> 15;
      quarter[k] = (v > 64'd32767) ? 64'd32767 : v;
    end
    for (int k = 0; k < TRIG_N; k++) begin
      j = k & (TRIG_N / 2 - 1);
      m = (j <= TRIG_N / 4) ? j : (TRIG_N / 2 - j);
      tab[k] = (k >= TRIG_N / 2) ? 16'(-int'(quarter[m])) : 16'(quarter[m]);
    end
    return tab;
  endfunction

  // tangent (sel 0) or secant squared (sel 1) at k/N rad, unsigned Q2.14
  function automatic trig_tab_t build_tan_tab(bit sel);
    trig_tab_t tab;
    longint unsigned th;
    longint unsigned s;
    longint unsigned c;
    longint unsigned c2;
    for (int k = 0; k < TRIG_N; k++) begin
      th = 64'(k) << (30 - TRIG_TABLE_BITS);
      s = trig_series(th, 1'b1);
      c = trig_series(th, 1'b0);
      if (c == 64'd0) c = 64'd1;
      c2 = (c * c) >> 30;
      if (c2 == 64'd0) c2 = 64'd1;
      if (sel) tab[k] = 16'(udiv64((64'd1 << 44) + c2 / 2, c2));
      else tab[k] = 16'(udiv64((s << 14) + c / 2, c));
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin_tab();
  localparam trig_tab_t TAN_TAB = build_tan_tab(1'b0);
  localparam trig_tab_t SEC2_TAB = build_tan_tab(1'b1);

endpackage
`default_nettype wire

// File: src/bms_ctrl.sv
// step sequencer for the bicycle model update
`default_nettype none
module bms_ctrl
  import bms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    out_ready,
  output logic         in_ready,
  output logic         out_valid,
  output dp_cmd_t      cmd
);

  logic [3:0] state;
  logic [3:0] state_next;

  // next state: idle waits for a transfer, steps run in order, output waits for sink
  always_comb begin
    unique case (state)
      ST_IDLE: state_next = in_valid ? ST_MUL_RATE : ST_IDLE;
      ST_OUT:  state_next = out_ready ? ST_IDLE : ST_OUT;
      default: state_next = state + 4'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshake and datapath commands
  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign cmd.step = state;
  assign cmd.load = in_valid && (state == ST_IDLE);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_MUL_RATE))
    else $error("load did not start the sequence");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

endmodule
`default_nettype wire

// File: src/bms_datapath.sv
// registers, tables and arithmetic for one bicycle model step
`default_nettype none
module bms_datapath
  import bms_pkg::*;
#(
  parameter int POS_FRAC_BITS = POSITION_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [15:0] in_rate,
  input  wire logic [15:0] in_velocity,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output logic [31:0]      pos_x,
  output logic [31:0]      pos_y,
  output logic [15:0]      heading,
  output logic [14:0]      steer
);

  localparam int TB = TRIG_TABLE_BITS;
  localparam int POS_SHIFT = 39 - POS_FRAC_BITS;

  // configuration and vehicle state
  logic [15:0] dt;
  logic [15:0] inv_l;
  logic [15:0] yaw;
  logic signed [15:0] steering;

  // operand and step registers
  logic signed [15:0] rate_q;
  logic signed [15:0] vel_q;
  logic [15:0] tan_q;
  logic [15:0] sec_q;
  logic signed [15:0] sin_q;
  logic signed [15:0] cos_q;
  logic signed [32:0] rdt_q;
  logic signed [15:0] s1_q;
  logic signed [34:0] inner_q;
  logic signed [34:0] acc1_q;
  logic signed [51:0] acc2_q;
  logic signed [52:0] acc3_q;
  logic [63:0] plo_q;
  logic [63:0] phi_q;
  logic [15:0] inc_q;
  logic signed [19:0] rad_q;
  logic signed [36:0] ix_q;
  logic signed [36:0] iy_q;
  logic signed [36:0] tx_q;
  logic signed [36:0] ty_q;
  logic signed [53:0] px_q;
  logic signed [53:0] py_q;

  // combinational terms
  logic signed [16:0] dt_s;
  logic signed [16:0] abs_s0;
  logic [TB-1:0] tab_idx;
  logic [TB-1:0] sin_idx;
  logic [TB-1:0] cos_idx;
  logic signed [19:0] s1_sum;
  logic signed [19:0] s1_sat;
  logic signed [16:0] diff;
  logic signed [16:0] tan_s;
  logic signed [50:0] iv_sum;
  logic signed [68:0] adt_sum;
  logic signed [63:0] plo_full;
  logic signed [63:0] phi_full;
  logic [63:0] yaw_sum;
  logic signed [48:0] rad_sum;
  logic signed [52:0] xv_sum;
  logic signed [52:0] yv_sum;
  logic signed [53:0] dx_sum;
  logic signed [53:0] dy_sum;
  logic signed [53:0] dx_sh;
  logic signed [53:0] dy_sh;

  assign dt_s = $signed({1'b0, dt});
  assign abs_s0 = steering[15] ? -17'(steering) : 17'(steering);
  assign tab_idx = TB'(abs_s0 >>> (14 - TB));
  assign sin_idx = yaw[15 -: TB];
  assign cos_idx = sin_idx + TB'(TRIG_N / 4);

  // steering update and rounding helpers
  always_comb begin
    s1_sum = 20'(steering) + 20'((rdt_q + 33'sd8192) >>> 14);
    if (s1_sum > 20'sd12868) s1_sat = 20'(STEER_LIMIT);
    else if (s1_sum < -20'sd12868) s1_sat = -20'(STEER_LIMIT);
    else s1_sat = s1_sum;
    diff = 17'(s1_q) - 17'(steering);
    tan_s = steering[15] ? -$signed({1'b0, tan_q}) : $signed({1'b0, tan_q});
    iv_sum = 51'(inner_q) * 51'(vel_q) + 51'sd32768;
    adt_sum = 69'(acc2_q) * 69'(dt_s) + 69'sd32768;
    plo_full = 64'(acc3_q) * 64'($signed({1'b0, UNITS_LO}));
    phi_full = 64'(acc3_q) * 64'($signed({1'b0, UNITS_HI}));
    yaw_sum = plo_q + (phi_q << 15) + (64'd1 << 47);
    rad_sum = 49'($signed(inc_q)) * 49'($signed({1'b0, PI_Q30})) + (49'sd1 <<< 28);
    xv_sum = 53'(ix_q) * 53'(vel_q) + 53'sd32768;
    yv_sum = 53'(iy_q) * 53'(vel_q) + 53'sd32768;
    dx_sum = px_q + (54'sd1 <<< (POS_SHIFT - 1));
    dy_sum = py_q + (54'sd1 <<< (POS_SHIFT - 1));
    dx_sh = dx_sum >>> POS_SHIFT;
    dy_sh = dy_sum >>> POS_SHIFT;
  end

  // registered table reads, indexed by the current steering angle and heading
  always_ff @(posedge clk) begin
    tan_q <= TAN_TAB[tab_idx];
    sec_q <= SEC2_TAB[tab_idx];
    sin_q <= $signed(SIN_TAB[sin_idx]);
    cos_q <= $signed(SIN_TAB[cos_idx]);
  end

  // step registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_q <= $signed(in_rate);
      vel_q <= $signed(in_velocity);
    end
    unique case (cmd.step)
      ST_MUL_RATE: rdt_q <= 33'(rate_q) * 33'(dt_s);
      ST_CLAMP:    s1_q <= 16'(s1_sat);
      ST_INNER:    inner_q <= (35'(tan_s) <<< 14) + 35'($signed({1'b0, sec_q})) * 35'(diff);
      ST_MUL_V:    acc1_q <= 35'(iv_sum >>> 16);
      ST_MUL_L:    acc2_q <= 52'(acc1_q) * 52'($signed({1'b0, inv_l}));
      ST_MUL_DT:   acc3_q <= 53'(adt_sum >>> 16);
      ST_MUL_ULO:  plo_q <= plo_full;
      ST_MUL_UHI:  phi_q <= phi_full;
      ST_YAW:      inc_q <= yaw_sum[63:48];
      ST_RAD:      rad_q <= 20'(rad_sum >>> 29);
      ST_IXY: begin
        ix_q <= (37'(cos_q) <<< 16) - 37'(sin_q) * 37'(rad_q);
        iy_q <= (37'(sin_q) <<< 16) + 37'(cos_q) * 37'(rad_q);
      end
      ST_XV: begin
        tx_q <= 37'(xv_sum >>> 16);
        ty_q <= 37'(yv_sum >>> 16);
      end
      ST_XDT: begin
        px_q <= 54'(tx_q) * 54'(dt_s);
        py_q <= 54'(ty_q) * 54'(dt_s);
      end
      default: begin
      end
    endcase
  end

  // configuration written on cfg_we, vehicle state updated at the end of a step
  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= TIME_STEP_RESET;
      inv_l <= INV_WHEELBASE_RESET;
      pos_x <= '0;
      pos_y <= '0;
      yaw <= '0;
      steering <= '0;
    end else begin
      if (cfg_we && cfg_addr == REG_TIME_STEP) dt <= cfg_wdata;
      if (cfg_we && cfg_addr == REG_INV_WHEELBASE) inv_l <= cfg_wdata;
      if (cmd.step == ST_COMMIT) begin
        pos_x <= pos_x + dx_sh[31:0];
        pos_y <= pos_y + dy_sh[31:0];
        yaw <= yaw + inc_q;
        steering <= s1_q;
      end
    end
  end

  assign heading = yaw;
  assign steer = steering[14:0];

  a_steer_range: assert property (@(posedge clk) disable iff (rst)
    (steering <= 16'sd12868) && (steering >= -16'sd12868))
    else $error("steering angle out of range");
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.step != ST_COMMIT) |=> ($stable(yaw) && $stable(steering)))
    else $error("vehicle state changed outside commit");
  a_yaw_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.step == ST_COMMIT) |=> (yaw == 16'($past(yaw) + $past(inc_q))))
    else $error("yaw commit mismatch");

endmodule
`default_nettype wire

// File: src/bicycle_model_step_top.sv
// top level of the bicycle model step block
// each item runs the 14 step sequence between the input accept and the output
// the sequencer runs one item at a time and reopens s_axis_tready after the result transfer
// reset: synchronous rst clears position, yaw and steering to zero and
// loads time_step 3277 and inverse_wheelbase 2048
`default_nettype none
module bicycle_model_step_top
  import bms_pkg::*;
#(
  parameter int POS_FRAC_BITS = POSITION_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // steering_rate[15:0], velocity[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64],
                                           // steer[94:80], zero[95]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_cmd_t cmd;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [15:0] heading;
  logic [14:0] steer;

  // sequencer
  bms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .cmd       (cmd)
  );

  // arithmetic and state
  bms_datapath #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_rate     (s_axis_tdata[15:0]),
    .in_velocity (s_axis_tdata[31:16]),
    .cfg_we      (cfg_valid),
    .cfg_addr    (cfg_index),
    .cfg_wdata   (cfg_data),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .steer       (steer)
  );

  // configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {1'b0, steer, heading, pos_y, pos_x};

endmodule
`default_nettype wire

// File: tb/bms_checker.sv
// checker for the bicycle model step: watches all channels, predicts each result and compares
module bms_checker
  import bms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAB = 1 << TRIG_TABLE_BITS;
  localparam int FRAC = POSITION_FRAC_BITS;
  localparam longint PI30 = 64'd3373259426;
  localparam longint unsigned RAD_TO_UNITS = 64'd683565276;
  localparam longint unsigned HALF_PI30 = 64'd1686629713;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
    logic [14:0] steer;
  } pose_t;

  int sine_q15 [NTAB];
  longint tan_q14 [NTAB];
  longint sec2_q14 [NTAB];

  logic [15:0] dt_reg, inv_l_reg;
  logic [31:0] cur_x, cur_y;
  logic [15:0] cur_yaw, cur_steer;
  pose_t pose_q [$];

  // taylor series in q30, sine when odd, cosine otherwise
  function automatic longint unsigned taylor_q30(longint unsigned x, bit odd);
    longint unsigned x2, term, n;
    longint sum;
    x2 = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    n = odd ? 1 : 0;
    sum = longint'(term);
    for (int i = 0; i < 12; i++) begin
      term = ((term * x2) >> 30) / ((n + 1) * (n + 2));
      n += 2;
      if (i % 2 == 1) sum += longint'(term);
      else sum -= longint'(term);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  function automatic longint round_shift(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // lookup tables
  initial begin
    longint unsigned quarter [NTAB/4+1];
    longint unsigned v, th, s, c, c2;
    int j, m;
    for (int k = 0; k <= NTAB / 4; k++) begin
      v = (taylor_q30(64'(k) * HALF_PI30 / (NTAB / 4), 1'b1) + 64'd16384) >> 15;
      quarter[k] = (v > 32767) ? 32767 : v;
    end
    for (int k = 0; k < NTAB; k++) begin
      j = k % (NTAB / 2);
      m = (j <= NTAB / 4) ? j : NTAB / 2 - j;
      sine_q15[k] = (k >= NTAB / 2) ? -int'(quarter[m]) : int'(quarter[m]);
      th = 64'(k) << (30 - TRIG_TABLE_BITS);
      s = taylor_q30(th, 1'b1);
      c = taylor_q30(th, 1'b0);
      if (c == 0) c = 1;
      c2 = (c * c) >> 30;
      if (c2 == 0) c2 = 1;
      tan_q14[k] = longint'(((s << 14) + c / 2) / c);
      sec2_q14[k] = longint'(((64'd1 << 44) + c2 / 2) / c2);
    end
  end

  // advance the vehicle by one step and return the new pose
  function automatic pose_t advance_vehicle(logic signed [15:0] rate, logic signed [15:0] vel);
    longint v, s0, s1, a0, t, sec, inner, acc, dd, rad16, sn, cs, ix, iy, dx, dy;
    longint unsigned p;
    int idx, k;
    logic [15:0] yaw1;
    pose_t r;
    v = vel;
    s0 = $signed(cur_steer);
    s1 = s0 + round_shift(longint'(rate) * longint'(dt_reg), 14);
    if (s1 > STEER_LIMIT) s1 = STEER_LIMIT;
    else if (s1 < -STEER_LIMIT) s1 = -STEER_LIMIT;
    a0 = (s0 < 0) ? -s0 : s0;
    idx = int'(a0 >> (14 - TRIG_TABLE_BITS)) % NTAB;
    t = (s0 < 0) ? -tan_q14[idx] : tan_q14[idx];
    sec = sec2_q14[idx];
    inner = t * 16384 + sec * (s1 - s0);
    acc = round_shift(inner * v, 16);
    acc = acc * longint'(inv_l_reg);
    acc = round_shift(acc * longint'(dt_reg), 16);
    p = longint'(acc) * RAD_TO_UNITS + (64'd1 << 47);
    yaw1 = cur_yaw + 16'(p >> 48);
    dd = longint'(16'(yaw1 - cur_yaw));
    if (dd >= 32768) dd -= 65536;
    rad16 = round_shift(dd * PI30, 29);
    k = cur_yaw >> (16 - TRIG_TABLE_BITS);
    sn = sine_q15[k % NTAB];
    cs = sine_q15[(k + NTAB / 4) % NTAB];
    ix = cs * 65536 - sn * rad16;
    iy = sn * 65536 + cs * rad16;
    dx = round_shift(round_shift(ix * v, 16) * longint'(dt_reg), 39 - FRAC);
    dy = round_shift(round_shift(iy * v, 16) * longint'(dt_reg), 39 - FRAC);
    cur_x = cur_x + 32'(dx);
    cur_y = cur_y + 32'(dy);
    cur_yaw = yaw1;
    cur_steer = 16'(s1);
    r.pos_x = cur_x;
    r.pos_y = cur_y;
    r.heading = cur_yaw;
    r.steer = 15'(s1);
    return r;
  endfunction

  assign pending = pose_q.size();

  // watch transfers on every rising edge
  always @(posedge clk) begin
    pose_t got, want;
    if (rst) begin
      dt_reg <= TIME_STEP_RESET;
      inv_l_reg <= INV_WHEELBASE_RESET;
      cur_x = 0;
      cur_y = 0;
      cur_yaw = 0;
      cur_steer = 0;
      pose_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TIME_STEP) dt_reg <= cfg_data;
        else if (cfg_index == REG_INV_WHEELBASE) inv_l_reg <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready)
        pose_q.push_back(advance_vehicle(s_axis_tdata[15:0], s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[79:64],
               m_axis_tdata[94:80]};
        if (pose_q.size() == 0) begin
          fail_count++;
          $display("%t: result with nothing expected, actual %h", $realtime, m_axis_tdata);
        end else begin
          want = pose_q.pop_front();
          if (got.pos_x !== want.pos_x) begin
            fail_count++;
            $display("%t: pos_x expected %h actual %h", $realtime, want.pos_x, got.pos_x);
          end
          if (got.pos_y !== want.pos_y) begin
            fail_count++;
            $display("%t: pos_y expected %h actual %h", $realtime, want.pos_y, got.pos_y);
          end
          if (got.heading !== want.heading) begin
            fail_count++;
            $display("%t: heading expected %h actual %h", $realtime, want.heading,
                     got.heading);
          end
          if (got.steer !== want.steer || m_axis_tdata[95] !== 1'b0) begin
            fail_count++;
            $display("%t: steer expected %h actual %h (pad %b)", $realtime, want.steer,
                     got.steer, m_axis_tdata[95]);
          end
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    results_seen = 0;
  end
endmodule

// File: tb/bicycle_model_step_top_tb.sv
// testbench top for the bicycle model step: clock, reset, stimulus and verdict
module bicycle_model_step_top_tb
  import bms_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 40;

  logic clk = 1'b0, rst = 1'b1;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [7:0] cfg_index = REG_TIME_STEP;
  logic [15:0] cfg_data = '0;
  int fail_count, pending, results_seen;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_request = 0;
  int cycles = 0;
  int items_sent = 0, cfg_writes = 0;

  bicycle_model_step_top i_dut (.*);

  bms_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bicycle_model_step_top: mismatch");
      $finish;
    end
  end

  // result side back-pressure, with a counted long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      m_axis_tready <= 1'b0;
      hold_request--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_step(logic [15:0] rate, logic [15:0] vel);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {vel, rate};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // wait until nothing is outstanding, then let the sequencer settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_steps(int count);
    logic [15:0] rate, vel;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: begin
          rate = 16'($urandom);
          vel = 16'($urandom);
        end
        1: begin
          rate = 16'($signed(10'($urandom)));
          vel = 16'($signed(12'($urandom)));
        end
        2: begin
          rate = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
          vel = 16'($urandom);
        end
        default: begin
          rate = 16'($signed(6'($urandom)));
          vel = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
        end
      endcase
      send_step(rate, vel);
    end
  endtask

  initial begin
    logic [15:0] dt_set [5];
    logic [15:0] inv_set [5];
    dt_set = '{16'd3277, 16'd1, 16'd65535, 16'd0, 16'd0};
    inv_set = '{16'd2048, 16'd65535, 16'd1, 16'd0, 16'd0};
    dt_set[3] = 16'($urandom_range(65535, 1));
    inv_set[3] = 16'($urandom_range(65535, 1));
    dt_set[4] = 16'd3277;
    inv_set[4] = 16'd2048;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, saturation both ways, zero crossings, yaw wrap
    send_step(16'h0000, 16'h0000);
    send_step(16'h7fff, 16'h0100);
    send_step(16'h7fff, 16'h7fff);
    send_step(16'h7fff, 16'h8000);
    send_step(16'h8000, 16'h7fff);
    send_step(16'h8000, 16'h8000);
    send_step(16'h8000, 16'h0100);
    send_step(16'h0000, 16'h7fff);
    send_step(16'h7fff, 16'hff00);
    send_step(16'h0001, 16'h0001);
    send_step(16'hffff, 16'hffff);
    send_step(16'h0000, 16'h8000);
    drain();
    write_reg(REG_INV_WHEELBASE, 16'hffff);
    write_reg(REG_TIME_STEP, 16'hffff);
    for (int n = 0; n < 6; n++) send_step(16'h7fff - 16'(n), 16'h7fff);
    send_step(16'h8000, 16'h8000);
    send_step(16'h8000, 16'h7fff);
    drain();

    // random phases over several register settings and idling mixes
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_TIME_STEP, dt_set[ph]);
      write_reg(REG_INV_WHEELBASE, inv_set[ph]);
      case (ph % 3)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      random_steps(160);
      if (ph == 0) begin
        // long receiver hold-off while items keep coming
        hold_request = 300;
        random_steps(20);
      end
      // sender pause until everything has come back
      s_axis_tvalid <= 1'b0;
      while (pending != 0) @(negedge clk);
      random_steps(160);
      drain();
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d steps, %0d results, %0d register writes", items_sent,
             results_seen, cfg_writes);
    $display("register sets include minimum, maximum, random and reset values");
    if (fail_count == 0 && pending == 0) begin
      $display("bicycle_model_step_top: match");
    end else begin
      $display("bicycle_model_step_top: mismatch");
    end
    $finish;
  end
endmodule
